FILE: rtl/grnw_pkg.sv
package grnw_pkg;

	// Field and register widths fixed by the interface.
	localparam int unsigned CFG_W = 7;
	localparam int unsigned IDX_W = 12;
	localparam int unsigned LVL_W = 4;

	// Largest value a dimension register can hold.
	localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;

	// Signed ring coordinate: index plus level plus sign.
	localparam int unsigned CRD_W = 14;

	// Cell counter of one ring, wide enough for eight times the level.
	localparam int unsigned CNT_W = LVL_W + 3;

	// Number of jobs held between divider and walker.
	localparam int unsigned Q_DEPTH = 2;

	// Default parameter values.
	localparam int unsigned MAX_DIM_DEF   = 64;
	localparam int unsigned MAX_LEVEL_DEF = 8;

	// Register indexes on the configuration port.
	typedef enum logic {
		REG_COLUMNS = 1'b0,
		REG_ROWS    = 1'b1
	} reg_idx_t;

	// One job handed from the divider to the walker.
	typedef struct packed {
		logic [CFG_W-1:0] cx;
		logic [IDX_W-1:0] cy;
		logic [LVL_W-1:0] lvl;
		logic [CFG_W-1:0] cols;
		logic [CFG_W-1:0] rows;
	} job_t;

	// Fill status of the job queue.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: rtl/grnw_front.sv
module grnw_front #(
	parameter int unsigned MAX_LEVEL = grnw_pkg::MAX_LEVEL_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// center_index [11:0], ring_level [15:12]
	input  logic [15:0]                s_tdata,
	input  logic [grnw_pkg::CFG_W-1:0] cols,
	input  logic [grnw_pkg::CFG_W-1:0] rows,
	input  grnw_pkg::qstat_t           qstat,
	output logic                       push,
	output grnw_pkg::job_t             job
);

	localparam int unsigned CFG_W = grnw_pkg::CFG_W;
	localparam int unsigned IDX_W = grnw_pkg::IDX_W;
	localparam int unsigned LVL_W = grnw_pkg::LVL_W;
	localparam int unsigned STP_W = $clog2(IDX_W);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} fstate_t;

	fstate_t            state_q;
	logic [STP_W-1:0]   step_q;
	logic [IDX_W-1:0]   quot_q;
	logic [CFG_W-1:0]   rem_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [CFG_W-1:0]   cols_q;
	logic [CFG_W-1:0]   rows_q;

	logic [IDX_W-1:0]   in_idx;
	logic [LVL_W-1:0]   in_lvl;
	logic [LVL_W-1:0]   lvl_clamped;
	logic [CFG_W:0]     trial;
	logic               qbit;
	logic [CFG_W-1:0]   rem_next;

	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_lvl = s_tdata[IDX_W+LVL_W-1:IDX_W];
	assign lvl_clamped = (in_lvl > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : in_lvl;

	// One restoring division step: bring down the next dividend bit.
	assign trial = {rem_q, quot_q[IDX_W-1]};
	assign qbit = (trial >= {1'b0, cols_q});
	assign rem_next = qbit ? CFG_W'(trial - {1'b0, cols_q}) : trial[CFG_W-1:0];

	assign s_tready = (state_q == F_IDLE);
	assign push = (state_q == F_PUSH) && !qstat.full;

	// The quotient is the centre row, the remainder the centre column.
	always_comb begin
		job.cx   = rem_q;
		job.cy   = quot_q;
		job.lvl  = lvl_q;
		job.cols = cols_q;
		job.rows = rows_q;
	end

	// Sequencer of the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						state_q <= F_DIV;
						step_q  <= '0;
					end
				end
				F_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STP_W'(IDX_W - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!qstat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Divider datapath and captured job fields.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && s_tvalid) begin
			quot_q <= in_idx;
			rem_q  <= '0;
			lvl_q  <= lvl_clamped;
			cols_q <= cols;
			rows_q <= rows;
		end else if (state_q == F_DIV) begin
			quot_q <= {quot_q[IDX_W-2:0], qbit};
			rem_q  <= rem_next;
		end
	end

endmodule

FILE: rtl/grnw_queue.sv
module grnw_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  grnw_pkg::job_t   wr_job,
	input  logic             pop,
	output grnw_pkg::job_t   rd_job,
	output grnw_pkg::qstat_t qstat
);

	localparam int unsigned DEPTH = grnw_pkg::Q_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	grnw_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

FILE: rtl/grnw_walker.sv
module grnw_walker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grnw_pkg::job_t       job,
	input  grnw_pkg::qstat_t     qstat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// neighbor_index [11:0], zero [15:12]
	output logic [15:0]          m_tdata,
	// found [0]
	output logic                 m_tuser,
	output logic                 m_tlast
);

	localparam int unsigned CFG_W = grnw_pkg::CFG_W;
	localparam int unsigned IDX_W = grnw_pkg::IDX_W;
	localparam int unsigned LVL_W = grnw_pkg::LVL_W;
	localparam int unsigned CRD_W = grnw_pkg::CRD_W;
	localparam int unsigned CNT_W = grnw_pkg::CNT_W;
	localparam int unsigned LIN_W = 2 * CFG_W;

	typedef enum logic [1:0] {
		W_IDLE,
		W_WALK,
		W_FLUSH
	} wstate_t;

	wstate_t                  state_q;
	logic signed [CRD_W-1:0]  x_q;
	logic signed [CRD_W-1:0]  y_q;
	logic [CNT_W-1:0]         n_q;
	logic [LVL_W-1:0]         lvl_q;
	logic [CFG_W-1:0]         cols_q;
	logic [CFG_W-1:0]         rows_q;
	logic                     pend_v_q;
	logic [IDX_W-1:0]         pend_q;
	logic                     out_v_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic                     out_found_q;
	logic                     out_last_q;

	logic                     out_free;
	logic                     out_load;
	logic                     in_grid;
	logic [LIN_W-1:0]         lin;
	logic [CNT_W-1:0]         l2;
	logic [CNT_W-1:0]         l4;
	logic [CNT_W-1:0]         l6;
	logic [CNT_W-1:0]         l8;
	logic [CNT_W-1:0]         n_last;

	assign out_free = !out_v_q || m_tready;
	assign pop = (state_q == W_IDLE) && !qstat.empty;

	// A held cell is released by the next in-grid cell or by the end of the walk.
	assign out_load = out_free &&
		(((state_q == W_WALK) && in_grid && pend_v_q) || (state_q == W_FLUSH));

	// Leg boundaries along the ring: 2L, 4L, 6L cells.
	assign l2 = CNT_W'({lvl_q, 1'b0});
	assign l4 = CNT_W'({lvl_q, 2'b0});
	assign l6 = l2 + l4;
	assign l8 = CNT_W'({lvl_q, 3'b0});
	assign n_last = (lvl_q == '0) ? '0 : l8 - 1'b1;

	// Bounds test of the current cell and its linear index.
	assign in_grid = !x_q[CRD_W-1] && !y_q[CRD_W-1] &&
		(x_q < $signed(CRD_W'(cols_q))) && (y_q < $signed(CRD_W'(rows_q)));
	assign lin = LIN_W'(y_q[CFG_W-1:0]) * LIN_W'(cols_q) + LIN_W'(x_q[CFG_W-1:0]);

	assign m_tvalid = out_v_q;
	assign m_tdata  = 16'(out_idx_q);
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

	// Ring sequencer: one cell a cycle while the output beat is free; the last
	// in-grid cell is held back until the walk shows whether it closes the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= W_IDLE;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			out_idx_q   <= '0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// The output beat is refilled or emptied once it has been taken.
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				W_IDLE: begin
					if (!qstat.empty) begin
						state_q  <= W_WALK;
						pend_v_q <= 1'b0;
					end
				end
				W_WALK: begin
					if (out_free) begin
						if (in_grid) begin
							if (pend_v_q) begin
								out_idx_q   <= pend_q;
								out_found_q <= 1'b1;
								out_last_q  <= 1'b0;
							end
							pend_v_q <= 1'b1;
						end
						if (n_q == n_last) begin
							state_q <= W_FLUSH;
						end
					end
				end
				W_FLUSH: begin
					if (out_free) begin
						out_idx_q   <= pend_v_q ? pend_q : '0;
						out_found_q <= pend_v_q;
						out_last_q  <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	// Walk position: start at the bottom-left corner, then right, up, left, down.
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= $signed(CRD_W'(job.cx)) - $signed(CRD_W'(job.lvl));
			y_q    <= $signed(CRD_W'(job.cy)) + $signed(CRD_W'(job.lvl));
			n_q    <= '0;
			lvl_q  <= job.lvl;
			cols_q <= job.cols;
			rows_q <= job.rows;
		end else if (state_q == W_WALK && out_free) begin
			n_q <= n_q + 1'b1;
			if (in_grid) begin
				pend_q <= lin[IDX_W-1:0];
			end
			if (n_q < l2) begin
				x_q <= x_q + 2'sd1;
			end else if (n_q < l4) begin
				y_q <= y_q - 2'sd1;
			end else if (n_q < l6) begin
				x_q <= x_q - 2'sd1;
			end else begin
				y_q <= y_q + 2'sd1;
			end
		end
	end

endmodule

FILE: rtl/grid_ring_neighbor_walker_top.sv
// Ring walker on a rectangular grid. Each input beat carries a linear centre
// index and a ring level; the block answers with one output beat for every
// grid cell at that Chebyshev distance, in the order bottom row left to
// right, right column upward, top row right to left, left column downward,
// and marks the final beat with tlast. A ring with no cell inside the grid
// gives one beat with found (tuser) low, index zero and tlast high. The
// front splits the index into column and row with a restoring divider and
// takes a new item only once its last job is in the queue; the back walks
// the ring one cell per cycle while tready does not hold the output back.
// A two-entry job queue lets both run at once. Grid dimensions are sampled
// when an item is taken.
module grid_ring_neighbor_walker_top #(
	parameter int unsigned MAX_DIM   = grnw_pkg::MAX_DIM_DEF,
	parameter int unsigned MAX_LEVEL = grnw_pkg::MAX_LEVEL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// center_index [11:0], ring_level [15:12]
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// neighbor_index [11:0], zero [15:12]
	output logic [15:0] m_tdata,
	// found [0]
	output logic        m_tuser,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CFG_W = grnw_pkg::CFG_W;
	localparam int unsigned DCAP  =
		(MAX_DIM < grnw_pkg::CFG_MAX) ? MAX_DIM : grnw_pkg::CFG_MAX;

	logic [CFG_W-1:0]   columns_q;
	logic [CFG_W-1:0]   rows_q;
	logic [CFG_W-1:0]   cols_eff;
	logic [CFG_W-1:0]   rows_eff;
	grnw_pkg::reg_idx_t reg_sel;
	logic               cfg_wr;

	logic               push;
	logic               pop;
	grnw_pkg::job_t     wr_job;
	grnw_pkg::job_t     rd_job;
	grnw_pkg::qstat_t   qstat;

	// Register file on the configuration port.
	assign pready  = 1'b1;
	assign reg_sel = grnw_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= CFG_W'(16);
			rows_q    <= CFG_W'(16);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				grnw_pkg::REG_COLUMNS: columns_q <= pwdata[CFG_W-1:0];
				grnw_pkg::REG_ROWS:    rows_q    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			grnw_pkg::REG_COLUMNS: prdata = 32'(columns_q);
			grnw_pkg::REG_ROWS:    prdata = 32'(rows_q);
			default:               prdata = '0;
		endcase
	end

	// A zero dimension counts as one, a large one is capped.
	always_comb begin
		cols_eff = columns_q;
		if (columns_q == '0) begin
			cols_eff = CFG_W'(1);
		end else if (columns_q > CFG_W'(DCAP)) begin
			cols_eff = CFG_W'(DCAP);
		end
		rows_eff = rows_q;
		if (rows_q == '0) begin
			rows_eff = CFG_W'(1);
		end else if (rows_q > CFG_W'(DCAP)) begin
			rows_eff = CFG_W'(DCAP);
		end
	end

	grnw_front #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.cols    (cols_eff),
		.rows    (rows_eff),
		.qstat   (qstat),
		.push    (push),
		.job     (wr_job)
	);

	grnw_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(wr_job),
		.pop   (pop),
		.rd_job(rd_job),
		.qstat (qstat)
	);

	grnw_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (rd_job),
		.qstat   (qstat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

`ifndef SYNTH
	// The divider never writes into a full queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("job written into a full queue");

	// The walker never takes a job from an empty queue.
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("job taken from an empty queue");

	// An empty-ring beat is always alone and carries index zero.
	a_empty_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 16'd0))
		else $error("empty-ring beat without tlast or with nonzero index");
`endif

endmodule
